/* sv/dle_pkg.sv */
// Shared types, codes and default values for the DLE framed packet deframer.
// Depends on nothing; used by dle_framed_packet_deframer.
package dle_pkg;

   localparam int HEADER_BYTES_DEF = 6;
   localparam int RECORD_BYTES_DEF = 256;
   localparam int FLAGS_INDEX_DEF  = 3;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 9;
   localparam int SUM_W   = 10;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_IDLE_ESC  = 2'd1,
      MODE_FRAME     = 2'd2,
      MODE_FRAME_ESC = 2'd3
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE         = 3'd0,
      ERR_SHORT_HEADER = 3'd1,
      ERR_BAD_ESCAPE   = 3'd2,
      ERR_SIZE_LIMIT   = 3'd3,
      ERR_OVERFLOW     = 3'd4,
      ERR_OVERLENGTH   = 3'd5
   } err_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DLE_CODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STX_CODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ETX_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOOTER_MASK = 3'd4;

   localparam logic [BYTE_W-1:0] DLE_CODE_RST    = 8'd16;
   localparam logic [BYTE_W-1:0] STX_CODE_RST    = 8'd2;
   localparam logic [BYTE_W-1:0] ETX_CODE_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd128;
   localparam logic [BYTE_W-1:0] FOOTER_MASK_RST = 8'd0;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] byte_value;
      logic [BYTE_W-1:0] byte_index;
      err_type           error_code;
      logic [POS_W-1:0]  frame_length;
   } rsp_type;

endpackage

/* sv/dle_framed_packet_deframer.sv */
// DLE/STX/ETX framed packet deframer with byte unstuffing, top level.
// Depends on dle_pkg for codes, types and register defaults.
//
// Usage:
// - req channel: one raw received byte per transaction (req_valid, req_stall,
//   req_rx_byte). The parser state is updated in the cycle the byte is taken.
// - rsp channel: at most one result per input byte: a stored byte with its
//   record index, a good frame end, or a frame error with its code.
// - csr port: csr_write_en, csr_index, csr_write_data write one of the five
//   8-bit registers (escape, start, end codes, payload limit, footer mask).
//   Write only while the block is idle.
// - A result is registered in the output register, or in the skid register.
// - Throughput: one byte per cycle while req_stall is low; the parser step
//   is one pass of compare and 10-bit add logic before the result register.
// - A two-entry output (result register plus skid register) lets the block
//   keep taking bytes while one result waits. req_stall rises only when both
//   entries hold results and the receiver stalls.
// - Reset (synchronous, active high) returns the parser to idle hunting for
//   the escape/start pair, clears the frame counters, empties the output and
//   loads the register defaults.
module dle_framed_packet_deframer #(
   parameter int HEADER_BYTES = dle_pkg::HEADER_BYTES_DEF,
   parameter int RECORD_BYTES = dle_pkg::RECORD_BYTES_DEF,
   parameter int FLAGS_INDEX  = dle_pkg::FLAGS_INDEX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dle_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dle_pkg::KIND_W-1:0]    rsp_kind,
   output logic [dle_pkg::BYTE_W-1:0]    rsp_byte_value,
   output logic [dle_pkg::BYTE_W-1:0]    rsp_byte_index,
   output logic [dle_pkg::ERR_W-1:0]     rsp_error_code,
   output logic [dle_pkg::POS_W-1:0]     rsp_frame_length,
   input  logic                          csr_write_en,
   input  logic [dle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dle_pkg::BYTE_W-1:0]    csr_write_data
);

   localparam logic [dle_pkg::POS_W-1:0] HDR_POS   = dle_pkg::POS_W'(HEADER_BYTES);
   localparam logic [dle_pkg::POS_W-1:0] HDR_LAST  = dle_pkg::POS_W'(HEADER_BYTES - 1);
   localparam logic [dle_pkg::POS_W-1:0] REC_POS   = dle_pkg::POS_W'(RECORD_BYTES);
   localparam logic [dle_pkg::POS_W-1:0] FLAGS_POS = dle_pkg::POS_W'(FLAGS_INDEX);
   localparam logic [dle_pkg::SUM_W-1:0] HDR_SUM   = dle_pkg::SUM_W'(HEADER_BYTES);

   // Configuration registers.
   logic [dle_pkg::BYTE_W-1:0] dle_code_ff, stx_code_ff, etx_code_ff;
   logic [dle_pkg::BYTE_W-1:0] max_payload_ff, footer_mask_ff;

   // Parser state.
   dle_pkg::mode_type          mode_ff, mode_in;
   logic [dle_pkg::POS_W-1:0]  wpos_ff, wpos_in;
   logic [dle_pkg::BYTE_W-1:0] payload_len_ff, payload_len_in;
   logic [dle_pkg::POS_W-1:0]  stored_cnt_ff, stored_cnt_in;
   logic [dle_pkg::BYTE_W-1:0] flags_ff, flags_in;

   // Output register and skid register.
   logic             rsp_valid_ff, rsp_valid_in;
   dle_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             skid_valid_ff, skid_valid_in;
   dle_pkg::rsp_type skid_data_ff, skid_data_in;

   logic             req_accept;
   logic             new_valid;
   dle_pkg::rsp_type new_data;

   // Store path intermediates.
   logic [dle_pkg::BYTE_W-1:0] st_payload_len, st_flags;
   logic [dle_pkg::POS_W-1:0]  st_wpos_inc, st_stored_inc;
   logic [dle_pkg::SUM_W-1:0]  footer_base, payload_end;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dle_code_ff    <= dle_pkg::DLE_CODE_RST;
         stx_code_ff    <= dle_pkg::STX_CODE_RST;
         etx_code_ff    <= dle_pkg::ETX_CODE_RST;
         max_payload_ff <= dle_pkg::MAX_PAYLOAD_RST;
         footer_mask_ff <= dle_pkg::FOOTER_MASK_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            dle_pkg::CSR_DLE_CODE:    dle_code_ff    <= csr_write_data;
            dle_pkg::CSR_STX_CODE:    stx_code_ff    <= csr_write_data;
            dle_pkg::CSR_ETX_CODE:    etx_code_ff    <= csr_write_data;
            dle_pkg::CSR_MAX_PAYLOAD: max_payload_ff <= csr_write_data;
            dle_pkg::CSR_FOOTER_MASK: footer_mask_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= dle_pkg::MODE_IDLE;
         wpos_ff        <= '0;
         payload_len_ff <= '0;
         stored_cnt_ff  <= '0;
         flags_ff       <= '0;
      end else if (req_accept) begin
         mode_ff        <= mode_in;
         wpos_ff        <= wpos_in;
         payload_len_ff <= payload_len_in;
         stored_cnt_ff  <= stored_cnt_in;
         flags_ff       <= flags_in;
      end
   end

   // Header and counter updates that a stored byte would make.
   always_comb begin
      st_payload_len = (wpos_ff == HDR_LAST) ? req_rx_byte : payload_len_ff;
      st_flags       = (wpos_ff == FLAGS_POS) ? req_rx_byte : flags_ff;
      st_wpos_inc    = wpos_ff + 1'b1;
      st_stored_inc  = stored_cnt_ff + 1'b1;
      footer_base    = HDR_SUM + dle_pkg::SUM_W'(max_payload_ff);
      payload_end    = HDR_SUM + dle_pkg::SUM_W'(st_payload_len);
   end

   always_comb begin
      logic do_store;
      logic finish;
      dle_pkg::err_type err;

      do_store       = 1'b0;
      finish         = 1'b0;
      err            = dle_pkg::ERR_NONE;
      mode_in        = mode_ff;
      wpos_in        = wpos_ff;
      payload_len_in = payload_len_ff;
      stored_cnt_in  = stored_cnt_ff;
      flags_in       = flags_ff;
      new_valid      = 1'b0;

      case (mode_ff)
         dle_pkg::MODE_IDLE: begin
            if (req_rx_byte == dle_code_ff) begin
               mode_in = dle_pkg::MODE_IDLE_ESC;
            end
         end
         dle_pkg::MODE_IDLE_ESC: begin
            if (req_rx_byte == stx_code_ff) begin
               mode_in        = dle_pkg::MODE_FRAME;
               wpos_in        = '0;
               payload_len_in = '0;
               stored_cnt_in  = '0;
               flags_in       = '0;
            end else begin
               mode_in = dle_pkg::MODE_IDLE;
            end
         end
         dle_pkg::MODE_FRAME: begin
            if (req_rx_byte == dle_code_ff) begin
               mode_in = dle_pkg::MODE_FRAME_ESC;
            end else begin
               do_store = 1'b1;
            end
         end
         dle_pkg::MODE_FRAME_ESC: begin
            if (req_rx_byte == etx_code_ff) begin
               finish = 1'b1;
               err    = (wpos_ff < HDR_POS) ? dle_pkg::ERR_SHORT_HEADER : dle_pkg::ERR_NONE;
            end else if (req_rx_byte != dle_code_ff) begin
               finish = 1'b1;
               err    = dle_pkg::ERR_BAD_ESCAPE;
            end else begin
               mode_in  = dle_pkg::MODE_FRAME;
               do_store = 1'b1;
            end
         end
         default: mode_in = dle_pkg::MODE_IDLE;
      endcase

      if (do_store) begin
         if (wpos_ff >= REC_POS) begin
            finish = 1'b1;
            err    = dle_pkg::ERR_OVERFLOW;
         end else begin
            payload_len_in = st_payload_len;
            flags_in       = st_flags;
            wpos_in        = st_wpos_inc;
            if (st_wpos_inc == HDR_POS && st_payload_len > max_payload_ff) begin
               finish = 1'b1;
               err    = dle_pkg::ERR_SIZE_LIMIT;
            end else begin
               // Once the payload is complete, jump to the footer area.
               if (st_wpos_inc >= HDR_POS
                   && dle_pkg::SUM_W'(st_wpos_inc) == payload_end) begin
                  wpos_in = dle_pkg::POS_W'(footer_base);
               end
               stored_cnt_in = st_stored_inc;
               if (dle_pkg::SUM_W'(st_stored_inc) > footer_base
                   && (st_flags & footer_mask_ff) == '0) begin
                  finish = 1'b1;
                  err    = dle_pkg::ERR_OVERLENGTH;
               end else begin
                  new_valid = 1'b1;
               end
            end
         end
      end

      if (finish) begin
         mode_in   = dle_pkg::MODE_IDLE;
         new_valid = 1'b1;
      end

      new_data.frame_length = stored_cnt_in;
      if (finish) begin
         new_data.kind       = (err == dle_pkg::ERR_NONE) ? dle_pkg::KIND_END
                                                          : dle_pkg::KIND_ERROR;
         new_data.byte_value = '0;
         new_data.byte_index = '0;
         new_data.error_code = err;
      end else begin
         new_data.kind       = dle_pkg::KIND_BYTE;
         new_data.byte_value = req_rx_byte;
         new_data.byte_index = wpos_ff[dle_pkg::BYTE_W-1:0];
         new_data.error_code = dle_pkg::ERR_NONE;
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      logic slot_free;
      slot_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept && new_valid) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = new_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_data;
         end
      end else if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_data_ff.kind;
   assign rsp_byte_value   = rsp_data_ff.byte_value;
   assign rsp_byte_index   = rsp_data_ff.byte_index;
   assign rsp_error_code   = rsp_data_ff.error_code;
   assign rsp_frame_length = rsp_data_ff.frame_length;

endmodule

/* tb/tb_dle_framed_packet_deframer.sv */
// Self-checking testbench for the DLE framed packet deframer: a queue-fed byte driver,
// a result monitor and a byte-level predictor of the unstuffing and framing rules.
// Depends on dle_pkg and dle_framed_packet_deframer.
module tb_dle_framed_packet_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_LEN     = dle_pkg::HEADER_BYTES_DEF;
   localparam int REC_LEN     = dle_pkg::RECORD_BYTES_DEF;
   localparam int FLAG_POS    = dle_pkg::FLAGS_INDEX_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_BYTES = 85;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [dle_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [dle_pkg::KIND_W-1:0]    rsp_kind;
   logic [dle_pkg::BYTE_W-1:0]    rsp_byte_value;
   logic [dle_pkg::BYTE_W-1:0]    rsp_byte_index;
   logic [dle_pkg::ERR_W-1:0]     rsp_error_code;
   logic [dle_pkg::POS_W-1:0]     rsp_frame_length;
   logic                          csr_write_en = 1'b0;
   logic [dle_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dle_pkg::BYTE_W-1:0]    csr_write_data = '0;

   dle_framed_packet_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_error_code   (rsp_error_code),
      .rsp_frame_length (rsp_frame_length),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Register copies used by the predictor and the frame generator.
   logic [dle_pkg::BYTE_W-1:0] cfg_dle    = dle_pkg::DLE_CODE_RST;
   logic [dle_pkg::BYTE_W-1:0] cfg_stx    = dle_pkg::STX_CODE_RST;
   logic [dle_pkg::BYTE_W-1:0] cfg_etx    = dle_pkg::ETX_CODE_RST;
   logic [dle_pkg::BYTE_W-1:0] cfg_max    = dle_pkg::MAX_PAYLOAD_RST;
   logic [dle_pkg::BYTE_W-1:0] cfg_footer = dle_pkg::FOOTER_MASK_RST;

   // Parser state of the predictor.
   dle_pkg::mode_type          pmode;
   int                         wr_pos;
   int                         pay_len;
   int                         n_stored;
   logic [dle_pkg::BYTE_W-1:0] flag_val;

   logic [dle_pkg::BYTE_W-1:0] rx_bytes_q[$];
   dle_pkg::rsp_type           expected_rsps[$];
   int                         data_count;
   int                         mismatches = 0;
   int                         send_gap = 0;
   bit                         send_calm = 1'b0;
   int                         stall_left = 0;
   bit                         recv_calm = 1'b0;
   int                         quiet_cycles = 0;

   function automatic dle_pkg::rsp_type make_rsp(dle_pkg::kind_type k,
                                                 logic [dle_pkg::BYTE_W-1:0] v,
                                                 logic [dle_pkg::BYTE_W-1:0] idx,
                                                 dle_pkg::err_type e);
      dle_pkg::rsp_type r;
      r.kind         = k;
      r.byte_value   = v;
      r.byte_index   = idx;
      r.error_code   = e;
      r.frame_length = n_stored[dle_pkg::POS_W-1:0];
      return r;
   endfunction

   function automatic dle_pkg::rsp_type end_frame(dle_pkg::err_type e);
      pmode = dle_pkg::MODE_IDLE;
      if (e == dle_pkg::ERR_NONE) begin
         return make_rsp(dle_pkg::KIND_END, '0, '0, e);
      end
      return make_rsp(dle_pkg::KIND_ERROR, '0, '0, e);
   endfunction

   function automatic dle_pkg::rsp_type store_byte(logic [dle_pkg::BYTE_W-1:0] b);
      int idx;
      idx = wr_pos;
      if (idx >= REC_LEN) return end_frame(dle_pkg::ERR_OVERFLOW);
      if (idx == HDR_LEN - 1) pay_len = b;
      if (idx == FLAG_POS) flag_val = b;
      wr_pos = idx + 1;
      // A size byte above the limit is counted as written but not as stored.
      if (wr_pos == HDR_LEN && pay_len > int'(cfg_max)) begin
         return end_frame(dle_pkg::ERR_SIZE_LIMIT);
      end
      if (wr_pos >= HDR_LEN && wr_pos == HDR_LEN + pay_len) wr_pos = HDR_LEN + int'(cfg_max);
      n_stored = (n_stored + 1) & 'h1FF;
      if (n_stored > HDR_LEN + int'(cfg_max) && (flag_val & cfg_footer) == '0) begin
         return end_frame(dle_pkg::ERR_OVERLENGTH);
      end
      return make_rsp(dle_pkg::KIND_BYTE, b, idx[dle_pkg::BYTE_W-1:0], dle_pkg::ERR_NONE);
   endfunction

   // Advances the predicted parser by one received byte and queues any result.
   function automatic void deframe_byte(logic [dle_pkg::BYTE_W-1:0] b);
      case (pmode)
         dle_pkg::MODE_IDLE: begin
            if (b == cfg_dle) pmode = dle_pkg::MODE_IDLE_ESC;
         end
         dle_pkg::MODE_IDLE_ESC: begin
            if (b == cfg_stx) begin
               pmode    = dle_pkg::MODE_FRAME;
               wr_pos   = 0;
               pay_len  = 0;
               n_stored = 0;
               flag_val = '0;
            end else begin
               pmode = dle_pkg::MODE_IDLE;
            end
         end
         dle_pkg::MODE_FRAME: begin
            if (b == cfg_dle) pmode = dle_pkg::MODE_FRAME_ESC;
            else expected_rsps.push_back(store_byte(b));
         end
         default: begin
            // The end code is tested before the escape code.
            if (b == cfg_etx) begin
               if (wr_pos < HDR_LEN) begin
                  expected_rsps.push_back(end_frame(dle_pkg::ERR_SHORT_HEADER));
               end else begin
                  expected_rsps.push_back(end_frame(dle_pkg::ERR_NONE));
               end
            end else if (b != cfg_dle) begin
               expected_rsps.push_back(end_frame(dle_pkg::ERR_BAD_ESCAPE));
            end else begin
               pmode = dle_pkg::MODE_FRAME;
               expected_rsps.push_back(store_byte(b));
            end
         end
      endcase
   endfunction

   function automatic int idle_len(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void put_raw(logic [dle_pkg::BYTE_W-1:0] b);
      rx_bytes_q.push_back(b);
   endfunction

   // Frame content byte, with the escape code doubled.
   function automatic void put_data(logic [dle_pkg::BYTE_W-1:0] b);
      if (b == cfg_dle) put_raw(b);
      put_raw(b);
      data_count++;
   endfunction

   function automatic void gen_frame();
      int sel;
      int plen;
      int foot;
      int stop;
      int i;
      bit big;
      bit open_end;
      logic [dle_pkg::BYTE_W-1:0] flags;
      logic [dle_pkg::BYTE_W-1:0] bad;
      logic [dle_pkg::BYTE_W-1:0] val;
      sel = $urandom_range(0, 99);
      if (sel >= 85) begin
         // Line noise between frames, rich in escape codes.
         for (i = 0; i < $urandom_range(1, 6); i++) begin
            if ($urandom_range(0, 2) == 0) put_raw(cfg_dle);
            else put_raw(8'($urandom_range(0, 255)));
         end
         return;
      end
      put_raw(cfg_dle);
      put_raw(cfg_stx);
      big = ($urandom_range(0, 24) == 0);
      if (big) begin
         plen = $urandom_range(0, int'(cfg_max));
         foot = $urandom_range(0, 255);
      end else begin
         plen = $urandom_range(0, (cfg_max < 12) ? int'(cfg_max) : 12);
         foot = $urandom_range(0, 3);
      end
      flags = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1 && cfg_footer != '0) begin
         flags = flags | (cfg_footer & (~cfg_footer + 8'd1));
      end else begin
         flags = flags & ~cfg_footer;
      end
      stop     = HDR_LEN + plen + foot;
      open_end = ($urandom_range(0, 19) == 0);
      if (sel >= 75 && cfg_max != 8'hFF) begin
         plen     = $urandom_range(int'(cfg_max) + 1, 255);
         stop     = HDR_LEN;
         open_end = 1'b1;
      end else if (sel >= 65) begin
         stop = $urandom_range(0, stop);
      end else if (sel >= 60) begin
         stop = $urandom_range(0, HDR_LEN - 1);
      end
      for (i = 0; i < stop; i++) begin
         if (i == FLAG_POS) val = flags;
         else if (i == HDR_LEN - 1) val = 8'(plen);
         else if ($urandom_range(0, 7) == 0) val = cfg_dle;
         else val = 8'($urandom_range(0, 255));
         put_data(val);
      end
      if (sel >= 65 && sel < 75) begin
         bad = 8'($urandom_range(0, 255));
         while (bad == cfg_etx || bad == cfg_dle) bad = 8'($urandom_range(0, 255));
         put_raw(cfg_dle);
         put_raw(bad);
      end else if (!open_end) begin
         put_raw(cfg_dle);
         put_raw(cfg_etx);
      end
   endfunction

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic apply_settings(input logic [dle_pkg::BYTE_W-1:0] d, s, e, m, f);
      logic [dle_pkg::BYTE_W-1:0]    vals[5];
      logic [dle_pkg::CSR_IDX_W-1:0] regs[5];
      vals = '{d, s, e, m, f};
      regs = '{dle_pkg::CSR_DLE_CODE, dle_pkg::CSR_STX_CODE, dle_pkg::CSR_ETX_CODE,
               dle_pkg::CSR_MAX_PAYLOAD, dle_pkg::CSR_FOOTER_MASK};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_index      <= regs[i];
         csr_write_data <= vals[i];
         case (regs[i])
            dle_pkg::CSR_DLE_CODE:    cfg_dle    = vals[i];
            dle_pkg::CSR_STX_CODE:    cfg_stx    = vals[i];
            dle_pkg::CSR_ETX_CODE:    cfg_etx    = vals[i];
            dle_pkg::CSR_MAX_PAYLOAD: cfg_max    = vals[i];
            default:                  cfg_footer = vals[i];
         endcase
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Holds the sender back until every pending byte is taken and every result is in.
   task automatic wait_drained();
      @(negedge clock);
      while (rx_bytes_q.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Byte driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         pmode    = dle_pkg::MODE_IDLE;
         wr_pos   = 0;
         pay_len  = 0;
         n_stored = 0;
         flag_val = '0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (rx_bytes_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_q.pop_front();
               if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
               send_gap = idle_len(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      dle_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, got kind %0d index %0d",
                        $time, rsp_kind, rsp_byte_index);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               report_field("kind", want.kind, rsp_kind);
               report_field("byte_value", want.byte_value, rsp_byte_value);
               report_field("byte_index", want.byte_index, rsp_byte_index);
               report_field("error_code", want.error_code, rsp_error_code);
               report_field("frame_length", want.frame_length, rsp_frame_length);
            end
         end
         if (stall_left == 0) begin
            if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
            stall_left = idle_len(recv_calm);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which no transaction of any kind happens.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes under the reset register values.
      // An escape in idle followed by a non-start byte is dropped.
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(8'h55);
      // Good frame with extreme header bytes, a doubled escape and an empty payload.
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::STX_CODE_RST);
      put_raw(8'h00); put_raw(8'hFF);
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::DLE_CODE_RST);
      put_raw(8'h5A); put_raw(8'hA5); put_raw(8'h00);
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::ETX_CODE_RST);
      // End right after the start: short header.
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::STX_CODE_RST);
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::ETX_CODE_RST);
      // Escape followed by an unknown byte.
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::STX_CODE_RST);
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(8'h77);
      // Payload size above the limit.
      put_raw(dle_pkg::DLE_CODE_RST); put_raw(dle_pkg::STX_CODE_RST);
      put_raw(8'h01); put_raw(8'h02); put_raw(8'h03); put_raw(8'h04); put_raw(8'h05);
      put_raw(8'hC8);
      wait_drained();

      for (int ph = 1; ph <= 6; ph++) begin
         case (ph)
            1: apply_settings(8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF);
            2: apply_settings(8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00);
            default: begin
               apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)),
                              ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 12))
                                                          : 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
         endcase
         @(negedge clock);
         data_count = 0;
         while (data_count < PHASE_BYTES) gen_frame();
         // Close any frame left open before the registers change.
         put_raw(cfg_dle);
         put_raw(cfg_etx);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
